// File: sv/scfa_pkg.sv
package scfa_pkg;

  localparam int unsigned MaxChunksDefault = 64;
  localparam int unsigned AddrBitsDefault  = 20;

  localparam int unsigned CmdBits   = 1;
  localparam int unsigned SizeBits  = 20;
  localparam int unsigned FaddrBits = 20;
  localparam int unsigned OutAddrW  = 20;
  localparam int unsigned GsizeBits = 10;
  localparam int unsigned StatBits  = 3;
  localparam int unsigned ClassBits = 3;
  localparam int unsigned LimitBits = 21;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 21;

  localparam logic [CfgIdxBits-1:0] CfgFitStrategy = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgHeapLimit   = 1'd1;

  localparam logic [CmdBits-1:0] CmdAlloc = 1'b0;
  localparam logic [CmdBits-1:0] CmdFree  = 1'b1;

  localparam logic [StatBits-1:0] StReused  = 3'd0;
  localparam logic [StatBits-1:0] StNew     = 3'd1;
  localparam logic [StatBits-1:0] StOom     = 3'd2;
  localparam logic [StatBits-1:0] StFreed   = 3'd3;
  localparam logic [StatBits-1:0] StUnknown = 3'd4;

  localparam logic [LimitBits-1:0] HeapLimitReset = 21'd1048576;

  // classified request handed from the front to the back
  typedef struct packed {
    logic [CmdBits-1:0]   cmd;
    logic [ClassBits-1:0] cls;
    logic [FaddrBits-1:0] faddr;
  } req_t;

  // class code of a request size
  function automatic logic [ClassBits-1:0] class_of(input logic [SizeBits-1:0] sz);
    logic [ClassBits-1:0] c;
    if (sz < 20'd32) c = 3'd0;
    else if (sz < 20'd64) c = 3'd1;
    else if (sz < 20'd128) c = 3'd2;
    else if (sz < 20'd256) c = 3'd3;
    else c = 3'd4;
    return c;
  endfunction

  // bytes of a class code; codes above four mean 512
  function automatic logic [GsizeBits-1:0] class_size(input logic [ClassBits-1:0] c);
    logic [GsizeBits-1:0] s;
    case (c)
      3'd0: s = 10'd32;
      3'd1: s = 10'd64;
      3'd2: s = 10'd128;
      3'd3: s = 10'd256;
      default: s = 10'd512;
    endcase
    return s;
  endfunction

endpackage

// File: sv/scfa_front.sv
// Accepts commands, classifies the size, and keeps a two-entry queue.
module scfa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [40:0]         in_data_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output scfa_pkg::req_t      q_data_o
);

  scfa_pkg::req_t  mem_q [2];
  logic            wr_q, rd_q, wr_d, rd_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;
  scfa_pkg::req_t  nreq;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // classify the incoming transaction
  always_comb begin
    nreq.cmd   = in_data_i[0];
    nreq.cls   = scfa_pkg::class_of(in_data_i[20:1]);
    nreq.faddr = in_data_i[40:21];
  end

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= nreq;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_full_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("ready while full");
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push lost");

endmodule

// File: sv/scfa_back.sv
// Scans the chunk table entry by entry (read, then evaluate) and produces the result.
module scfa_back #(
  parameter int unsigned MaxChunks = scfa_pkg::MaxChunksDefault,
  parameter int unsigned AddrBits  = scfa_pkg::AddrBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fit_i,
  input  logic [scfa_pkg::LimitBits-1:0] limit_i,
  input  logic                           q_valid_i,
  output logic                           q_ready_o,
  input  scfa_pkg::req_t                 q_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [39:0]                    out_data_o
);

  localparam int unsigned IdxW = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int unsigned CntW = $clog2(MaxChunks + 1);
  localparam int unsigned TopW = AddrBits + 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MaxChunks);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SEval = 3'd2;
  localparam logic [2:0] SDone = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;

  typedef struct packed {
    logic [AddrBits-1:0]           base;
    logic [scfa_pkg::ClassBits-1:0] cls;
  } ent_t;

  ent_t              tab_q [MaxChunks];
  logic              use_q [MaxChunks];
  ent_t              rd_ent_q;
  logic              rd_use_q;

  logic [2:0]        st_q, st_d;
  scfa_pkg::req_t    req_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TopW-1:0]   top_q, top_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   pick_q, pick_d;
  logic [scfa_pkg::GsizeBits-1:0] best_q, best_d;
  logic [AddrBits-1:0] pbase_q, pbase_d;
  logic              fit_q;
  logic [AddrBits-1:0] oaddr_q, oaddr_d;
  logic [scfa_pkg::GsizeBits-1:0] osize_q, osize_d;
  logic [scfa_pkg::StatBits-1:0]  ostat_q, ostat_d;

  logic              last;
  logic [scfa_pkg::GsizeBits-1:0] esz, need;
  logic              hit;
  logic [TopW:0]     lim, sum;
  logic              tab_we, use_we, use_val;
  logic [IdxW-1:0]   use_idx;

  assign q_ready_o   = (st_q == SIdle);
  assign out_valid_o = (st_q == SOut);
  assign out_data_o  = {7'd0, ostat_q, osize_q, scfa_pkg::OutAddrW'(oaddr_q)};
  assign need = scfa_pkg::class_size(req_q.cls);
  assign esz  = scfa_pkg::class_size(rd_ent_q.cls);
  assign last = ({1'b0, idx_q} + 1'b1) >= (IdxW+1)'(cnt_q);

  // does the entry just read match the request
  always_comb begin
    if (req_q.cmd == scfa_pkg::CmdFree)
      hit = rd_use_q && (rd_ent_q.base == AddrBits'(req_q.faddr));
    else
      hit = !rd_use_q && (esz >= need) && (!fit_q || !found_q || esz < best_q);
  end

  always_comb begin
    lim = (TopW+1)'(limit_i);
    if (lim > (TopW+1)'(1) << AddrBits) lim = (TopW+1)'(1) << AddrBits;
    sum = {1'b0, top_q} + (TopW+1)'(need);
  end

  always_comb begin
    st_d = st_q; idx_d = idx_q; cnt_d = cnt_q; top_d = top_q;
    found_d = found_q; pick_d = pick_q; best_d = best_q; pbase_d = pbase_q;
    oaddr_d = oaddr_q; osize_d = osize_q; ostat_d = ostat_q;
    tab_we = 1'b0; use_we = 1'b0; use_val = 1'b0; use_idx = pick_q;
    unique case (st_q)
      SIdle: if (q_valid_i) begin
        idx_d = '0; found_d = 1'b0;
        st_d = (cnt_q == '0) ? SDone : SRead;
      end
      SRead: st_d = SEval;
      SEval: begin
        if (hit) begin
          found_d = 1'b1; pick_d = idx_q; best_d = esz; pbase_d = rd_ent_q.base;
        end
        if ((hit && (req_q.cmd == scfa_pkg::CmdFree || !fit_q)) || last) st_d = SDone;
        else begin
          idx_d = idx_q + 1'b1; st_d = SRead;
        end
      end
      SDone: begin
        oaddr_d = '0; osize_d = '0; st_d = SOut;
        if (req_q.cmd == scfa_pkg::CmdFree) begin
          ostat_d = found_q ? scfa_pkg::StFreed : scfa_pkg::StUnknown;
          use_we = found_q;
        end else if (found_q) begin
          ostat_d = scfa_pkg::StReused; oaddr_d = pbase_q;
          osize_d = best_q; use_we = 1'b1; use_val = 1'b1;
        end else if (cnt_q >= CntMax || sum > lim) begin
          ostat_d = scfa_pkg::StOom;
        end else begin
          ostat_d = scfa_pkg::StNew; oaddr_d = top_q[AddrBits-1:0]; osize_d = need;
          tab_we = 1'b1; use_we = 1'b1; use_val = 1'b1; use_idx = cnt_q[IdxW-1:0];
          cnt_d = cnt_q + 1'b1; top_d = sum[TopW-1:0];
        end
      end
      SOut: if (out_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; top_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && q_valid_i) begin
      req_q <= q_data_i; fit_q <= fit_i;
    end
    idx_q <= idx_d; found_q <= found_d; pick_q <= pick_d; best_q <= best_d;
    pbase_q <= pbase_d; oaddr_q <= oaddr_d; osize_q <= osize_d; ostat_q <= ostat_d;
  end

  // chunk table, registered read
  always_ff @(posedge clk_i) begin
    if (tab_we) tab_q[cnt_q[IdxW-1:0]] <= '{base: top_q[AddrBits-1:0], cls: req_q.cls};
    rd_ent_q <= tab_q[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (use_we) use_q[use_idx] <= use_val;
    rd_use_q <= use_q[idx_q];
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntMax)
    else $error("chunk count above table depth");
  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SDone && tab_we |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count not bumped");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ostat_q)) else $error("result lost");

endmodule

// File: sv/size_class_fit_allocator.sv
// Channel   Direction  Payload
// s_axis    in         tuser: command; tdata: request_size[19:0], free_address[39:20]
// m_axis    out        tdata: address[19:0], granted_size[29:20], status[32:30]
// cfg       in         0 fit_strategy, 1 heap_limit
//
// An item passes idle, then a read and an evaluate state per table entry scanned (up to
// the chunk count), then the done and output states of the back end.
// Reset clears counts, heap top and queue; the table needs no clearing.
// The front queue holds two commands while the back scans or its result waits.
module size_class_fit_allocator #(
  parameter int unsigned MaxChunks = scfa_pkg::MaxChunksDefault,
  parameter int unsigned AddrBits  = scfa_pkg::AddrBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,  // command
  input  logic [39:0] s_axis_tdata,  // request_size, free_address
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // address, granted_size, status
  input  logic        cfg_we_i,
  input  logic [scfa_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [scfa_pkg::CfgDataBits-1:0] cfg_data_i
);

  logic                           fit_q;
  logic [scfa_pkg::LimitBits-1:0] limit_q;
  logic                           q_valid, q_ready;
  scfa_pkg::req_t                 q_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= 1'b0;
      limit_q <= scfa_pkg::HeapLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scfa_pkg::CfgFitStrategy: fit_q <= cfg_data_i[0];
        scfa_pkg::CfgHeapLimit:   limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scfa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i({s_axis_tdata, s_axis_tuser}),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  scfa_back #(.MaxChunks(MaxChunks), .AddrBits(AddrBits)) u_back (
    .clk_i, .rst_ni, .fit_i(fit_q), .limit_i(limit_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );

endmodule

// File: dv/tb_size_class_fit_allocator.sv
module tb_size_class_fit_allocator;

  localparam int unsigned NumChunks = scfa_pkg::MaxChunksDefault;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 150;

  localparam int unsigned CmdBits     = scfa_pkg::CmdBits;
  localparam int unsigned SizeBits    = scfa_pkg::SizeBits;
  localparam int unsigned FaddrBits   = scfa_pkg::FaddrBits;
  localparam int unsigned OutAddrW    = scfa_pkg::OutAddrW;
  localparam int unsigned GsizeBits   = scfa_pkg::GsizeBits;
  localparam int unsigned StatBits    = scfa_pkg::StatBits;
  localparam int unsigned ClassBits   = scfa_pkg::ClassBits;
  localparam int unsigned LimitBits   = scfa_pkg::LimitBits;
  localparam int unsigned CfgIdxBits  = scfa_pkg::CfgIdxBits;
  localparam int unsigned CfgDataBits = scfa_pkg::CfgDataBits;

  typedef struct packed {
    logic [CmdBits-1:0]   cmd;
    logic [SizeBits-1:0]  size;
    logic [FaddrBits-1:0] faddr;
  } alloc_req_t;

  typedef struct packed {
    logic [OutAddrW-1:0]  addr;
    logic [GsizeBits-1:0] gsize;
    logic [StatBits-1:0]  status;
  } alloc_rsp_t;

  typedef struct packed {
    alloc_req_t req;
    logic       typed;
    alloc_rsp_t rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic s_axis_tuser = 1'b0;       // command
  logic [39:0] s_axis_tdata = '0;  // request_size, free_address
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // address, granted_size, status
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  size_class_fit_allocator DUT (.*);

  // shadow allocator state
  logic [OutAddrW-1:0]  sh_base [NumChunks];
  logic [ClassBits-1:0] sh_cls [NumChunks];
  logic                 sh_used [NumChunks];
  int unsigned          sh_count;
  logic [LimitBits:0]   sh_top;
  logic                 sh_best_fit;
  logic [LimitBits-1:0] sh_limit;

  alloc_rsp_t pending_rsp[$];
  int unsigned errors = 0;
  int unsigned rx_count = 0;
  logic accepted_any;

  function automatic logic [ClassBits-1:0] size_code(logic [SizeBits-1:0] sz);
    if (sz < 32) return 3'd0;
    if (sz < 64) return 3'd1;
    if (sz < 128) return 3'd2;
    if (sz < 256) return 3'd3;
    return 3'd4;
  endfunction

  function automatic logic [GsizeBits-1:0] code_bytes(logic [ClassBits-1:0] c);
    return (c > 3'd4) ? 10'd512 : (10'd32 << c);
  endfunction

  // compute one response and advance the shadow state
  function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
    alloc_rsp_t o;
    logic [GsizeBits-1:0] need, sz, best;
    logic [LimitBits:0] lim;
    int pick;
    o = '0;
    pick = -1;
    best = '0;
    if (r.cmd == scfa_pkg::CmdFree) begin
      o.status = scfa_pkg::StUnknown;
      for (int i = 0; i < sh_count; i++) begin
        if (sh_used[i] && sh_base[i] == r.faddr) begin
          sh_used[i] = 1'b0;
          o.status = scfa_pkg::StFreed;
          break;
        end
      end
      return o;
    end
    need = code_bytes(size_code(r.size));
    for (int i = 0; i < sh_count; i++) begin
      if (sh_used[i]) continue;
      sz = code_bytes(sh_cls[i]);
      if (sz < need) continue;
      if (!sh_best_fit) begin
        pick = i;
        break;
      end
      if (pick < 0 || sz < best) begin
        pick = i;
        best = sz;
      end
    end
    if (pick >= 0) begin
      sh_used[pick] = 1'b1;
      o.addr = sh_base[pick];
      o.gsize = code_bytes(sh_cls[pick]);
      o.status = scfa_pkg::StReused;
      return o;
    end
    // limit saturates at the address space
    lim = {1'b0, sh_limit};
    if (lim > (LimitBits+1)'(1) << OutAddrW) lim = (LimitBits+1)'(1) << OutAddrW;
    if (sh_count >= NumChunks || sh_top + need > lim) begin
      o.status = scfa_pkg::StOom;
      return o;
    end
    sh_base[sh_count] = sh_top[OutAddrW-1:0];
    sh_cls[sh_count] = size_code(r.size);
    sh_used[sh_count] = 1'b1;
    sh_count++;
    o.addr = sh_top[OutAddrW-1:0];
    o.gsize = need;
    o.status = scfa_pkg::StNew;
    sh_top = sh_top + need;
    return o;
  endfunction

  // random request, mostly allocs of small classes and frees of live chunks
  function automatic alloc_req_t random_req();
    alloc_req_t r;
    int live[$];
    r.size = SizeBits'($urandom());
    r.faddr = FaddrBits'($urandom());
    r.cmd = ($urandom_range(0, 9) < 6) ? scfa_pkg::CmdAlloc : scfa_pkg::CmdFree;
    if (r.cmd == scfa_pkg::CmdAlloc && $urandom_range(0, 4) != 0)
      r.size = SizeBits'($urandom_range(0, 300));
    if (r.cmd == scfa_pkg::CmdFree && $urandom_range(0, 4) != 0) begin
      for (int i = 0; i < sh_count; i++)
        if (sh_used[i]) live = {live, i};
      if (live.size() > 0) r.faddr = sh_base[live[$urandom_range(0, live.size() - 1)]];
    end
    return r;
  endfunction

  // directed rows: class boundaries, frees, reuse of a larger chunk
  stim_row_t directed [] = '{
    '{'{scfa_pkg::CmdAlloc, 20'd0, 20'd0},       1'b1, '{20'd0,    10'd32,  scfa_pkg::StNew}},
    '{'{scfa_pkg::CmdAlloc, 20'd31, 20'hFFFFF},  1'b1, '{20'd32,   10'd32,  scfa_pkg::StNew}},
    '{'{scfa_pkg::CmdAlloc, 20'd32, 20'd0},      1'b1, '{20'd64,   10'd64,  scfa_pkg::StNew}},
    '{'{scfa_pkg::CmdAlloc, 20'd63, 20'd0},      1'b1, '{20'd128,  10'd64,  scfa_pkg::StNew}},
    '{'{scfa_pkg::CmdAlloc, 20'd64, 20'd0},      1'b1, '{20'd192,  10'd128, scfa_pkg::StNew}},
    '{'{scfa_pkg::CmdAlloc, 20'd255, 20'd0},     1'b1, '{20'd320,  10'd256, scfa_pkg::StNew}},
    '{'{scfa_pkg::CmdAlloc, 20'd256, 20'd0},     1'b1, '{20'd576,  10'd512, scfa_pkg::StNew}},
    '{'{scfa_pkg::CmdAlloc, 20'hFFFFF, 20'd0},   1'b1, '{20'd1088, 10'd512, scfa_pkg::StNew}},
    '{'{scfa_pkg::CmdFree, 20'd0, 20'd0},        1'b1, '{20'd0,    10'd0,   scfa_pkg::StFreed}},
    '{'{scfa_pkg::CmdFree, 20'd0, 20'd0},        1'b1, '{20'd0,    10'd0,   scfa_pkg::StUnknown}},
    '{'{scfa_pkg::CmdFree, 20'hFFFFF, 20'hFFFFF}, 1'b1, '{20'd0,   10'd0,   scfa_pkg::StUnknown}},
    '{'{scfa_pkg::CmdFree, 20'd0, 20'd64},       1'b1, '{20'd0,    10'd0,   scfa_pkg::StFreed}},
    '{'{scfa_pkg::CmdAlloc, 20'd1, 20'd0},       1'b1, '{20'd0,    10'd32,  scfa_pkg::StReused}},
    '{'{scfa_pkg::CmdAlloc, 20'd33, 20'd0},      1'b1, '{20'd64,   10'd64,  scfa_pkg::StReused}},
    '{'{scfa_pkg::CmdFree, 20'd0, 20'd576},      1'b1, '{20'd0,    10'd0,   scfa_pkg::StFreed}},
    '{'{scfa_pkg::CmdAlloc, 20'd100, 20'd0},     1'b1, '{20'd576,  10'd512, scfa_pkg::StReused}},
    '{'{scfa_pkg::CmdFree, 20'd0, 20'd1088},     1'b0, '0},
    '{'{scfa_pkg::CmdFree, 20'd0, 20'd320},      1'b0, '0},
    '{'{scfa_pkg::CmdAlloc, 20'd0, 20'd0},       1'b0, '0},
    '{'{scfa_pkg::CmdAlloc, 20'd200, 20'd0},     1'b0, '0}
  };

  // offer one transaction after a random gap, wait for acceptance
  task automatic send_req(alloc_req_t r, logic typed, alloc_rsp_t rsp);
    int unsigned gap;
    alloc_rsp_t exp_rsp;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser <= r.cmd;
    s_axis_tdata <= {r.faddr, r.size};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_rsp = predict_alloc(r);
    if (typed) exp_rsp = rsp;
    pending_rsp = {pending_rsp, exp_rsp};
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == scfa_pkg::CfgFitStrategy) sh_best_fit = val[0];
    else sh_limit = val[LimitBits-1:0];
  endtask

  task automatic random_phase(int unsigned n);
    for (int k = 0; k < n; k++) send_req(random_req(), 1'b0, '0);
  endtask

  // stimulus
  initial begin
    sh_count = 0;
    sh_top = '0;
    sh_best_fit = 1'b0;
    sh_limit = scfa_pkg::HeapLimitReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_req(directed[i].req, directed[i].typed, directed[i].rsp);
    write_reg(scfa_pkg::CfgFitStrategy, 21'd1);
    write_reg(scfa_pkg::CfgHeapLimit, 21'h1FFFFF);
    random_phase(150);
    write_reg(scfa_pkg::CfgFitStrategy, 21'd0);
    write_reg(scfa_pkg::CfgHeapLimit, 21'd0);
    random_phase(100);
    write_reg(scfa_pkg::CfgFitStrategy, 21'd1);
    write_reg(scfa_pkg::CfgHeapLimit,
              LimitBits'(sh_top[LimitBits-1:0] + $urandom_range(0, 2000)));
    random_phase(100);
    write_reg(scfa_pkg::CfgFitStrategy, 21'd0);
    write_reg(scfa_pkg::CfgHeapLimit, scfa_pkg::HeapLimitReset);
    random_phase(100);
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // response side: random backpressure plus one long hold-off
  initial begin
    alloc_rsp_t got, want;
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = (rx_count == 200) ? HoldCycles : $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0 && rx_count != 200) gap = 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.addr = m_axis_tdata[19:0];
      got.gsize = m_axis_tdata[29:20];
      got.status = m_axis_tdata[32:30];
      rx_count++;
      if (pending_rsp.size() == 0) begin
        $error("response transaction with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.addr !== want.addr) begin
          $error("address: expected %0d, got %0d", want.addr, got.addr);
          errors++;
        end
        if (got.gsize !== want.gsize) begin
          $error("granted_size: expected %0d, got %0d", want.gsize, got.gsize);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      accepted_any = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);
      quiet = accepted_any ? 0 : quiet + 1;
      if (quiet >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// File: size_class_fit_allocator.f
sv/scfa_pkg.sv
sv/scfa_front.sv
sv/scfa_back.sv
sv/size_class_fit_allocator.sv
dv/tb_size_class_fit_allocator.sv
